// ===== rtl/mcst_pkg.sv =====
package mcst_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic        is_ipv6;
    logic [63:0] group_hi;
    logic [63:0] group_lo;
    logic [4:0]  station;
    logic [15:0] source_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] member_map;
  } rsp_t;

  localparam logic [2:0] KIND_JOIN    = 3'd0;
  localparam logic [2:0] KIND_LEAVE   = 3'd1;
  localparam logic [2:0] KIND_INCLUDE = 3'd2;
  localparam logic [2:0] KIND_LOOKUP  = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  localparam logic [2:0] V_DELIVER  = 3'd0;
  localparam logic [2:0] V_PLAIN    = 3'd1;
  localparam logic [2:0] V_DROP     = 3'd2;
  localparam logic [2:0] V_UPDATED  = 3'd3;
  localparam logic [2:0] V_NOCHANGE = 3'd4;
  localparam logic [2:0] V_FULL     = 3'd5;

  localparam logic       CFG_RMCAST = 1'b0;
  localparam logic       CFG_AP     = 1'b1;

  localparam logic [31:0] V4_LL_MASK  = 32'hFFFFFF00;
  localparam logic [31:0] V4_LL_VALUE = 32'hE0000000;
  localparam logic [31:0] V6_LL_MASK  = 32'hFF0F0000;
  localparam logic [31:0] V6_LL_VALUE = 32'hFF020000;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_CREATE = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PURGE  = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
  } cmd_t;

  // running flags passed from cell to cell
  typedef struct packed {
    logic claimed;
    logic hit;
    logic drop;
  } link_t;

endpackage

// ===== rtl/multicast_snooping_table.sv =====
// Multicast group table with per-group station bitmaps.
// Requests enter on in_valid/in_stall carrying in_data; one result per
// request leaves on out_valid/out_stall carrying out_data. Both sides
// transfer when valid is high and stall is low.
// Each request passes through capture, a search along the row of group
// cells (match, lowest free slot, members, drop hits), then the update
// and result write. A new request is taken only once the last one has
// left the update; the cell-to-cell search chain sets the clock period.
// The result register holds its value while out_valid and out_stall are
// high; the update waits until it can be loaded, and in_stall stays high.
// Registers are written on cfg_valid/cfg_ready (always ready), index 0
// rmcast_enable, index 1 ap_mode; write them only when idle.
// Reset (rst, synchronous) empties every group, clears rmcast_enable and
// sets ap_mode. The table is usable in the cycle after reset.
module multicast_snooping_table #(
  parameter int GROUP_ENTRIES = 64,
  parameter int STATIONS      = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mcst_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mcst_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic           cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  mcst_pkg::req_t       req;
  logic                 rmcast_enable;
  logic                 ap_mode;

  logic                 hit_any;
  logic                 free_any;
  logic                 drop_any;
  logic [STATIONS-1:0]  hit_map;

  mcst_pkg::cmd_t       cmd;
  mcst_pkg::op_t        op;
  logic [STATIONS-1:0]  mask;
  logic                 sta_ok;
  logic                 link_local;
  logic                 can_load;
  logic [2:0]           verdict;
  logic [STATIONS-1:0]  map_sel;
  logic [63:0]          map_wide;

  mcst_pkg::link_t      links [GROUP_ENTRIES+1];
  logic [STATIONS-1:0]  maps  [GROUP_ENTRIES+1];
  logic [GROUP_ENTRIES-1:0] hits;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign can_load  = !out_valid || !out_stall;

  assign sta_ok = 32'(req.station) < 32'(STATIONS);
  assign mask   = sta_ok ? (STATIONS'(1) << req.station) : '0;

  assign cmd.v6 = req.is_ipv6;
  assign cmd.hi = req.is_ipv6 ? req.group_hi : 64'd0;
  assign cmd.lo = req.is_ipv6 ? req.group_lo : {32'd0, req.group_lo[31:0]};
  assign cmd.op = (state == S_APPLY && can_load) ? op : mcst_pkg::OP_NONE;

  assign link_local = req.is_ipv6 ?
      ((req.group_hi[63:32] & mcst_pkg::V6_LL_MASK) == mcst_pkg::V6_LL_VALUE) :
      ((req.group_lo[31:0] & mcst_pkg::V4_LL_MASK) == mcst_pkg::V4_LL_VALUE);

  assign links[0] = '0;
  assign maps[0]  = '0;

  for (genvar g = 0; g < GROUP_ENTRIES; g++) begin : g_cell
    mcst_cell #(.STATIONS(STATIONS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .mask     (mask),
      .link_in  (links[g]),
      .map_in   (maps[g]),
      .link_out (links[g+1]),
      .map_out  (maps[g+1]),
      .hit      (hits[g])
    );
  end

  always_comb begin
    op      = mcst_pkg::OP_NONE;
    verdict = mcst_pkg::V_NOCHANGE;
    map_sel = '0;
    priority if (req.kind == mcst_pkg::KIND_LOOKUP) begin
      priority if (!rmcast_enable || !ap_mode || link_local) begin
        verdict = mcst_pkg::V_PLAIN;
      end else if (!hit_any) begin
        verdict = mcst_pkg::V_DROP;
      end else begin
        verdict = mcst_pkg::V_DELIVER;
        map_sel = hit_map & ~mask;
      end
    end else if (req.kind == mcst_pkg::KIND_JOIN) begin
      if (ap_mode && sta_ok && !link_local) begin
        priority if (!hit_any && !free_any) begin
          verdict = mcst_pkg::V_FULL;
        end else if (!hit_any) begin
          op      = mcst_pkg::OP_CREATE;
          verdict = mcst_pkg::V_UPDATED;
          map_sel = mask;
        end else if ((hit_map & mask) == '0) begin
          op      = mcst_pkg::OP_ADD;
          verdict = mcst_pkg::V_UPDATED;
          map_sel = hit_map | mask;
        end else begin
          map_sel = hit_map;
        end
      end
    end else if (req.kind == mcst_pkg::KIND_LEAVE ||
                 (req.kind == mcst_pkg::KIND_INCLUDE && req.source_count == 16'd0)) begin
      if (ap_mode && sta_ok && hit_any) begin
        if ((hit_map & mask) != '0) begin
          op      = mcst_pkg::OP_REMOVE;
          verdict = mcst_pkg::V_UPDATED;
          map_sel = hit_map & ~mask;
        end else begin
          map_sel = hit_map;
        end
      end
    end else if (req.kind == mcst_pkg::KIND_INCLUDE) begin
      if (ap_mode && sta_ok && hit_any) map_sel = hit_map;
    end else if (req.kind == mcst_pkg::KIND_DROP) begin
      if (ap_mode && sta_ok) begin
        op = mcst_pkg::OP_PURGE;
        if (drop_any) verdict = mcst_pkg::V_UPDATED;
      end
    end
  end

  assign map_wide = 64'(map_sel);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MATCH;
      S_MATCH: state_next = S_APPLY;
      S_APPLY: if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      rmcast_enable <= 1'b0;
      ap_mode       <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          mcst_pkg::CFG_RMCAST: rmcast_enable <= cfg_data;
          mcst_pkg::CFG_AP:     ap_mode       <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == S_APPLY && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) req <= in_data;
    // hold the search results for the update cycle
    if (state == S_MATCH) begin
      hit_any  <= links[GROUP_ENTRIES].hit;
      free_any <= links[GROUP_ENTRIES].claimed;
      drop_any <= links[GROUP_ENTRIES].drop;
      hit_map  <= maps[GROUP_ENTRIES];
    end
    if (state == S_APPLY && can_load) begin
      out_data.verdict    <= verdict;
      out_data.member_map <= map_wide[31:0];
    end
  end

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $countones(hits) <= 1)
    else $error("group present in more than one cell");

  a_accept_match: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MATCH))
    else $error("accepted request did not start a search");

  a_match_apply: assert property (@(posedge clk) disable iff (rst)
    (state == S_MATCH) |=> (state == S_APPLY))
    else $error("search not followed by update");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && can_load) |=> (out_valid && state == S_IDLE))
    else $error("update finished without a result");

endmodule

// ===== rtl/mcst_cell.sv =====
module mcst_cell #(
  parameter int STATIONS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcst_pkg::cmd_t       cmd,
  input  logic [STATIONS-1:0]  mask,
  input  mcst_pkg::link_t      link_in,
  input  logic [STATIONS-1:0]  map_in,
  output mcst_pkg::link_t      link_out,
  output logic [STATIONS-1:0]  map_out,
  output logic                 hit
);

  logic                valid;
  logic                v6;
  logic [63:0]         hi;
  logic [63:0]         lo;
  logic [STATIONS-1:0] members;
  logic [STATIONS-1:0] cleared;
  logic                has_bit;
  logic                take;

  assign hit     = valid && (v6 == cmd.v6) && (hi == cmd.hi) && (lo == cmd.lo);
  assign has_bit = valid && ((members & mask) != '0);
  assign take    = !valid && !link_in.claimed;
  assign cleared = members & ~mask;

  assign link_out.claimed = link_in.claimed || !valid;
  assign link_out.hit     = link_in.hit || hit;
  assign link_out.drop    = link_in.drop || has_bit;
  assign map_out          = map_in | (hit ? members : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      v6      <= 1'b0;
      members <= '0;
    end else begin
      unique case (cmd.op)
        mcst_pkg::OP_CREATE: begin
          if (take) begin
            valid   <= 1'b1;
            v6      <= cmd.v6;
            hi      <= cmd.hi;
            lo      <= cmd.lo;
            members <= mask;
          end
        end
        mcst_pkg::OP_ADD: begin
          if (hit) members <= members | mask;
        end
        mcst_pkg::OP_REMOVE: begin
          if (hit) begin
            members <= cleared;
            if (cleared == '0) begin
              valid <= 1'b0;
              v6    <= 1'b0;
            end
          end
        end
        mcst_pkg::OP_PURGE: begin
          if (has_bit) begin
            members <= cleared;
            if (cleared == '0) begin
              valid <= 1'b0;
              v6    <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
